// File: rtl/core/sctcf_pkg.sv
// shared types and constants for the sorted coo to csf fiber builder
package sctcf_pkg;

   localparam int MAX_LEVELS_DEF = 8;
   localparam int INDEX_BITS_DEF = 32;
   localparam int LVL_SLOTS      = 8;
   localparam int COORD_W        = 32;
   localparam int PTR_W          = 32;
   localparam int VALUE_W        = 64;
   localparam int LVL_W          = 3;
   localparam int NLEV_W         = 4;

   localparam logic [NLEV_W-1:0] NUM_MODES_RESET = 4'd3;

   localparam logic [1:0] KIND_FIBER = 2'd0;
   localparam logic [1:0] KIND_LEAF  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // one accepted request, resolved against the tree state
   typedef struct packed {
      logic [LVL_SLOTS-1:0][COORD_W-1:0] coord;
      logic [VALUE_W-1:0]                value;
      logic                              final_nz;
      logic [NLEV_W-1:0]                 start;
      logic [LVL_W-1:0]                  leaf;
      logic [LVL_SLOTS-1:0][PTR_W-1:0]   fib_ptr;
      logic [LVL_SLOTS-1:0][PTR_W-1:0]   end_ptr;
   } item_type;

endpackage

// File: rtl/core/sorted_coo_to_csf_fibers.sv
// top level of the sorted coo to csf fiber builder
//
//   channel  dir  handshake           payload
//   req_     in   req_valid/req_stall coord_level0..7, nonzero_value, final_nonzero
//   rsp_     out  rsp_valid/rsp_stall record_kind, record_level, fiber_coord,
//                                     child_pointer, leaf_value, last_record
//   csr_     in   csr_write_enable    csr_write_data (num_modes)
//
// a request with f new fibers gives f+1 records, plus clamped num_modes-1 end
// pointers when it is the final nonzero; one record leaves per cycle while the
// response is not stalled. the input register takes the next request while the
// sequencer still works, and the tree state updates as a request enters it.
// reset (synchronous) empties both registers, clears the tree state and
// sets num_modes to three; a stalled response holds and backs up to req_stall
module sorted_coo_to_csf_fibers import sctcf_pkg::*; #(
   parameter int MAX_LEVELS = MAX_LEVELS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [NLEV_W-1:0]   csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [COORD_W-1:0]  req_coord_level0,
   input  logic [COORD_W-1:0]  req_coord_level1,
   input  logic [COORD_W-1:0]  req_coord_level2,
   input  logic [COORD_W-1:0]  req_coord_level3,
   input  logic [COORD_W-1:0]  req_coord_level4,
   input  logic [COORD_W-1:0]  req_coord_level5,
   input  logic [COORD_W-1:0]  req_coord_level6,
   input  logic [COORD_W-1:0]  req_coord_level7,
   input  logic [VALUE_W-1:0]  req_nonzero_value,
   input  logic                req_final_nonzero,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_record_kind,
   output logic [LVL_W-1:0]    rsp_record_level,
   output logic [COORD_W-1:0]  rsp_fiber_coord,
   output logic [PTR_W-1:0]    rsp_child_pointer,
   output logic [VALUE_W-1:0]  rsp_leaf_value,
   output logic                rsp_last_record
);

   // mode count register and its clamped form
   logic [NLEV_W-1:0] num_modes_ff;
   logic [NLEV_W-1:0] nlev;
   logic [LVL_W-1:0]  leaf;

   // input register
   logic                              a_valid_ff;
   logic [LVL_SLOTS-1:0][COORD_W-1:0] a_coord_ff;
   logic [VALUE_W-1:0]                a_value_ff;
   logic                              a_final_ff;
   logic [LVL_SLOTS-1:0][COORD_W-1:0] coord_in;

   logic     load_ok;
   logic     take;
   item_type item;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_modes_ff <= NUM_MODES_RESET;
      end else if (csr_write_enable) begin
         num_modes_ff <= csr_write_data;
      end
   end

   // values below two act as two, above the tree depth as the depth
   always_comb begin
      nlev = num_modes_ff;
      if (num_modes_ff < NLEV_W'(2)) begin
         nlev = NLEV_W'(2);
      end else if (num_modes_ff > NLEV_W'(MAX_LEVELS)) begin
         nlev = NLEV_W'(MAX_LEVELS);
      end
   end
   assign leaf = LVL_W'(nlev - NLEV_W'(1));

   assign coord_in = {req_coord_level7, req_coord_level6, req_coord_level5, req_coord_level4,
                      req_coord_level3, req_coord_level2, req_coord_level1, req_coord_level0};

   // the held request moves on once the sequencer is free or finishing
   assign take      = a_valid_ff && load_ok;
   assign req_stall = a_valid_ff && !load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         a_coord_ff <= coord_in;
         a_value_ff <= req_nonzero_value;
         a_final_ff <= req_final_nonzero;
      end
   end

   sctcf_track #(
      .MAX_LEVELS (MAX_LEVELS),
      .INDEX_BITS (INDEX_BITS)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .take_i  (take),
      .coord_i (a_coord_ff),
      .value_i (a_value_ff),
      .final_i (a_final_ff),
      .nlev_i  (nlev),
      .leaf_i  (leaf),
      .item_o  (item)
   );

   sctcf_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load_i            (take),
      .item_i            (item),
      .load_ok_o         (load_ok),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_record_level  (rsp_record_level),
      .rsp_fiber_coord   (rsp_fiber_coord),
      .rsp_child_pointer (rsp_child_pointer),
      .rsp_leaf_value    (rsp_leaf_value),
      .rsp_last_record   (rsp_last_record)
   );

   a_nlev_range: assert property (@(posedge clock) disable iff (reset)
      (nlev >= NLEV_W'(2)) && (nlev <= NLEV_W'(MAX_LEVELS)))
      else $error("clamped mode count out of range");
   a_stall_only_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff)
      else $error("request stalled with nothing pending");
   a_take_held: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && req_stall) |=> a_valid_ff)
      else $error("held request dropped");

endmodule

// File: rtl/core/sctcf_track.sv
// tree state: previous coordinates, per-level fiber counts, divergence level
module sctcf_track import sctcf_pkg::*; #(
   parameter int MAX_LEVELS = MAX_LEVELS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take_i,
   input  logic [LVL_SLOTS-1:0][COORD_W-1:0] coord_i,
   input  logic [VALUE_W-1:0]                value_i,
   input  logic                              final_i,
   input  logic [NLEV_W-1:0]                 nlev_i,
   input  logic [LVL_W-1:0]                  leaf_i,
   output item_type                          item_o
);

   logic [COORD_W-1:0]    prev_ff [MAX_LEVELS];
   logic [COORD_W-1:0]    prev_in [MAX_LEVELS];
   logic [INDEX_BITS-1:0] cnt_ff  [MAX_LEVELS];
   logic [INDEX_BITS-1:0] cnt_in  [MAX_LEVELS];
   logic [INDEX_BITS-1:0] cnt_new [MAX_LEVELS];
   logic                  first_ff;
   logic                  first_in;
   logic [NLEV_W-1:0]     start;
   logic                  found;

   always_comb begin
      start = nlev_i;
      found = 1'b0;
      if (first_ff) begin
         start = '0;
      end else begin
         for (int l = 0; l < MAX_LEVELS; l++) begin
            if (!found && (NLEV_W'(l) < nlev_i) && (coord_i[l] != prev_ff[l])) begin
               start = NLEV_W'(l);
               found = 1'b1;
            end
         end
      end
   end

   // new fibers from the divergence level down, and the leaf count on every nonzero
   always_comb begin
      for (int l = 0; l < MAX_LEVELS; l++) begin
         if (((NLEV_W'(l) >= start) && (LVL_W'(l) < leaf_i)) || (LVL_W'(l) == leaf_i)) begin
            cnt_new[l] = cnt_ff[l] + INDEX_BITS'(1);
         end else begin
            cnt_new[l] = cnt_ff[l];
         end
      end
   end

   always_comb begin
      item_o          = '0;
      item_o.coord    = coord_i;
      item_o.value    = value_i;
      item_o.final_nz = final_i;
      item_o.start    = start;
      item_o.leaf     = leaf_i;
      for (int l = 0; l < MAX_LEVELS - 1; l++) begin
         item_o.fib_ptr[l] = PTR_W'(cnt_ff[l+1]);
         item_o.end_ptr[l] = PTR_W'(cnt_new[l+1]);
      end
   end

   always_comb begin
      first_in = first_ff;
      for (int l = 0; l < MAX_LEVELS; l++) begin
         prev_in[l] = prev_ff[l];
         cnt_in[l]  = cnt_ff[l];
      end
      if (take_i) begin
         if (final_i) begin
            first_in = 1'b1;
            for (int l = 0; l < MAX_LEVELS; l++) begin
               prev_in[l] = '0;
               cnt_in[l]  = '0;
            end
         end else begin
            first_in = 1'b0;
            for (int l = 0; l < MAX_LEVELS; l++) begin
               cnt_in[l] = cnt_new[l];
               if (NLEV_W'(l) < nlev_i) begin
                  prev_in[l] = coord_i[l];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         for (int l = 0; l < MAX_LEVELS; l++) begin
            prev_ff[l] <= '0;
            cnt_ff[l]  <= '0;
         end
      end else begin
         first_ff <= first_in;
         for (int l = 0; l < MAX_LEVELS; l++) begin
            prev_ff[l] <= prev_in[l];
            cnt_ff[l]  <= cnt_in[l];
         end
      end
   end

   a_first_start: assert property (@(posedge clock) disable iff (reset)
      first_ff |-> (start == '0))
      else $error("first nonzero must start at the root level");
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (take_i && final_i) |=> (first_ff && (cnt_ff[0] == '0)))
      else $error("final nonzero did not clear the tree state");
   a_leaf_counts: assert property (@(posedge clock) disable iff (reset)
      (take_i && !final_i) |=> (cnt_ff[$past(leaf_i)] == $past(cnt_ff[leaf_i]) + INDEX_BITS'(1)))
      else $error("leaf count did not advance");

endmodule

// File: rtl/core/sctcf_emit.sv
// record sequencer and response register
module sctcf_emit import sctcf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_i,
   input  item_type            item_i,
   output logic                load_ok_o,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_record_kind,
   output logic [LVL_W-1:0]    rsp_record_level,
   output logic [COORD_W-1:0]  rsp_fiber_coord,
   output logic [PTR_W-1:0]    rsp_child_pointer,
   output logic [VALUE_W-1:0]  rsp_leaf_value,
   output logic                rsp_last_record
);

   typedef enum logic [2:0] {
      PH_FIBER = 3'b001,
      PH_LEAF  = 3'b010,
      PH_END   = 3'b100
   } phase_type;

   item_type          item_ff;
   logic              busy_ff, busy_in;
   phase_type         phase_ff, phase_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic              valid_ff;
   logic              out_free, step, done;
   logic [1:0]        kind;
   logic [COORD_W-1:0] coord;
   logic [PTR_W-1:0]  ptr;
   logic [VALUE_W-1:0] value;
   logic              last;
   logic [LVL_W-1:0]  lvl_nx;

   assign out_free  = !valid_ff || !rsp_stall;
   assign step      = busy_ff && out_free;
   assign done      = step && last;
   assign load_ok_o = !busy_ff || done;
   assign lvl_nx    = lvl_ff + LVL_W'(1);

   always_comb begin
      kind  = KIND_LEAF;
      coord = '0;
      ptr   = '0;
      value = '0;
      last  = 1'b0;
      case (phase_ff)
         PH_FIBER: begin
            kind  = KIND_FIBER;
            coord = item_ff.coord[lvl_ff];
            ptr   = item_ff.fib_ptr[lvl_ff];
         end
         PH_LEAF: begin
            kind  = KIND_LEAF;
            coord = item_ff.coord[lvl_ff];
            value = item_ff.value;
            last  = !item_ff.final_nz;
         end
         PH_END: begin
            kind = KIND_END;
            ptr  = item_ff.end_ptr[lvl_ff];
            last = (lvl_nx == item_ff.leaf);
         end
         default: begin
            kind = KIND_LEAF;
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      lvl_in   = lvl_ff;
      if (step) begin
         case (phase_ff)
            PH_FIBER: begin
               if (lvl_nx == item_ff.leaf) begin
                  phase_in = PH_LEAF;
               end
               lvl_in = lvl_nx;
            end
            PH_LEAF: begin
               if (item_ff.final_nz) begin
                  phase_in = PH_END;
                  lvl_in   = '0;
               end else begin
                  busy_in = 1'b0;
               end
            end
            PH_END: begin
               lvl_in = lvl_nx;
               if (last) begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
      if (load_i) begin
         busy_in = 1'b1;
         if (item_i.start < {1'b0, item_i.leaf}) begin
            phase_in = PH_FIBER;
            lvl_in   = item_i.start[LVL_W-1:0];
         end else begin
            phase_in = PH_LEAF;
            lvl_in   = item_i.leaf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_LEAF;
         lvl_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         lvl_ff   <= lvl_in;
         if (out_free) begin
            valid_ff <= step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         item_ff <= item_i;
      end
      if (step) begin
         rsp_record_kind   <= kind;
         rsp_record_level  <= lvl_ff;
         rsp_fiber_coord   <= coord;
         rsp_child_pointer <= ptr;
         rsp_leaf_value    <= value;
         rsp_last_record   <= last;
      end
   end

   assign rsp_valid = valid_ff;

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot(phase_ff))
      else $error("sequencer phase not one-hot");
   a_fiber_below_leaf: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && phase_ff == PH_FIBER) |-> (lvl_ff < item_ff.leaf))
      else $error("fiber record at or below leaf level");
   a_end_only_final: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && phase_ff == PH_END) |-> item_ff.final_nz)
      else $error("end pointers for a non-final nonzero");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load_i |-> load_ok_o)
      else $error("new request loaded over an unfinished one");

endmodule

// File: test/sorted_coo_to_csf_fibers_checker.sv
// record predictor and scoreboard for the coo to csf fiber builder
`timescale 1ns / 100ps
module sorted_coo_to_csf_fibers_checker import sctcf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [NLEV_W-1:0]  csr_write_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [COORD_W-1:0] req_coord_level0,
   input  logic [COORD_W-1:0] req_coord_level1,
   input  logic [COORD_W-1:0] req_coord_level2,
   input  logic [COORD_W-1:0] req_coord_level3,
   input  logic [COORD_W-1:0] req_coord_level4,
   input  logic [COORD_W-1:0] req_coord_level5,
   input  logic [COORD_W-1:0] req_coord_level6,
   input  logic [COORD_W-1:0] req_coord_level7,
   input  logic [VALUE_W-1:0] req_nonzero_value,
   input  logic               req_final_nonzero,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_record_kind,
   input  logic [LVL_W-1:0]   rsp_record_level,
   input  logic [COORD_W-1:0] rsp_fiber_coord,
   input  logic [PTR_W-1:0]   rsp_child_pointer,
   input  logic [VALUE_W-1:0] rsp_leaf_value,
   input  logic               rsp_last_record,
   output int                 failures,
   output int                 records_due
);

   typedef struct packed {
      logic [1:0]         kind;
      logic [LVL_W-1:0]   level;
      logic [COORD_W-1:0] coord;
      logic [PTR_W-1:0]   ptr;
      logic [VALUE_W-1:0] value;
      logic               last;
   } csf_record_type;

   csf_record_type     csf_record_q[$];
   logic [NLEV_W-1:0]  modes_reg;
   logic [COORD_W-1:0] last_coord [LVL_SLOTS];
   logic [PTR_W-1:0]   fibers_seen [LVL_SLOTS];
   logic               new_tensor;
   int                 fail_count = 0;

   assign failures = fail_count;

   function automatic csf_record_type make_record(logic [1:0] kind, int level,
                                                  logic [COORD_W-1:0] coord,
                                                  logic [PTR_W-1:0] ptr,
                                                  logic [VALUE_W-1:0] value, logic last);
      csf_record_type r;
      r.kind  = kind;
      r.level = LVL_W'(level);
      r.coord = coord;
      r.ptr   = ptr;
      r.value = value;
      r.last  = last;
      return r;
   endfunction

   function automatic void clear_tree();
      for (int i = 0; i < LVL_SLOTS; i++) begin
         last_coord[i]  = '0;
         fibers_seen[i] = '0;
      end
      new_tensor = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                       logic [VALUE_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // fiber starts from the first new level, then the leaf, then end pointers on the final one
   task automatic predict_records(input logic [LVL_SLOTS-1:0][COORD_W-1:0] coord,
                                  input logic [VALUE_W-1:0] value, input logic fin);
      int depth;
      int leaf;
      int first_new;
      int lvl;
      if (modes_reg < 2)
         depth = 2;
      else if (modes_reg > MAX_LEVELS_DEF)
         depth = MAX_LEVELS_DEF;
      else
         depth = int'(modes_reg);
      leaf      = depth - 1;
      first_new = new_tensor ? 0 : depth;
      for (lvl = depth - 1; lvl >= 0; lvl--)
         if (!new_tensor && coord[lvl] !== last_coord[lvl]) first_new = lvl;
      for (lvl = first_new; lvl < leaf; lvl++) begin
         csf_record_q.push_back(make_record(KIND_FIBER, lvl, coord[lvl], fibers_seen[lvl + 1],
                                            '0, 1'b0));
         fibers_seen[lvl] = fibers_seen[lvl] + 1'b1;
      end
      csf_record_q.push_back(make_record(KIND_LEAF, leaf, coord[leaf], '0, value, !fin));
      fibers_seen[leaf] = fibers_seen[leaf] + 1'b1;
      for (lvl = 0; lvl < depth; lvl++) last_coord[lvl] = coord[lvl];
      new_tensor = 1'b0;
      if (fin) begin
         for (lvl = 0; lvl < leaf; lvl++)
            csf_record_q.push_back(make_record(KIND_END, lvl, '0, fibers_seen[lvl + 1], '0,
                                               lvl == leaf - 1));
         clear_tree();
      end
   endtask

   always @(posedge clock) begin
      csf_record_type want;
      if (reset) begin
         csf_record_q.delete();
         modes_reg = NUM_MODES_RESET;
         clear_tree();
      end else begin
         if (csr_write_enable) modes_reg = csr_write_data;
         if (req_valid && !req_stall)
            predict_records({req_coord_level7, req_coord_level6, req_coord_level5,
                             req_coord_level4, req_coord_level3, req_coord_level2,
                             req_coord_level1, req_coord_level0},
                            req_nonzero_value, req_final_nonzero);
         if (rsp_valid && !rsp_stall) begin
            if (csf_record_q.size() == 0) begin
               fail_count++;
               $display("%0t: record expected none, got kind %0h level %0h coord %0h",
                        $time, rsp_record_kind, rsp_record_level, rsp_fiber_coord);
            end else begin
               want = csf_record_q.pop_front();
               check_field("record_kind", want.kind, rsp_record_kind);
               check_field("record_level", want.level, rsp_record_level);
               check_field("fiber_coord", want.coord, rsp_fiber_coord);
               check_field("child_pointer", want.ptr, rsp_child_pointer);
               check_field("leaf_value", want.value, rsp_leaf_value);
               check_field("last_record", want.last, rsp_last_record);
            end
         end
      end
      records_due <= csf_record_q.size();
   end

endmodule

// File: test/sorted_coo_to_csf_fibers_tb.sv
// testbench top for the coo to csf fiber builder: stimulus, idling and verdict
`timescale 1ns / 100ps
module sorted_coo_to_csf_fibers_tb;
   import sctcf_pkg::*;

   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES = 8;     // sequencer drain before a register write
   localparam int DRAIN_CYCLES  = 20;    // watch for stray records at the end
   localparam int ITEM_TARGET   = 330;
   localparam int QUIET_FROM    = 290;   // no idling from here on

   typedef logic [LVL_SLOTS-1:0][COORD_W-1:0] coord_set_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [NLEV_W-1:0]  csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic [COORD_W-1:0] req_coord_level0;
   logic [COORD_W-1:0] req_coord_level1;
   logic [COORD_W-1:0] req_coord_level2;
   logic [COORD_W-1:0] req_coord_level3;
   logic [COORD_W-1:0] req_coord_level4;
   logic [COORD_W-1:0] req_coord_level5;
   logic [COORD_W-1:0] req_coord_level6;
   logic [COORD_W-1:0] req_coord_level7;
   logic [VALUE_W-1:0] req_nonzero_value;
   logic               req_final_nonzero;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_record_kind;
   logic [LVL_W-1:0]   rsp_record_level;
   logic [COORD_W-1:0] rsp_fiber_coord;
   logic [PTR_W-1:0]   rsp_child_pointer;
   logic [VALUE_W-1:0] rsp_leaf_value;
   logic               rsp_last_record;

   int                 failures;
   int                 records_due;

   bit                 gaps_on;
   int                 stall_left;
   int                 items_sent;
   logic [NLEV_W-1:0]  modes_now;    // our copy of num_modes, steers the generator only
   coord_set_type      walk;         // coordinates of the tensor being walked in order
   int                 tensor_left;  // nonzeros still to come in that tensor, 0 when none open

   sorted_coo_to_csf_fibers DUT (.*);

   sorted_coo_to_csf_fibers_checker u_checker (.*);

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // one request, held until taken; may open with an idle burst
   task automatic push_nonzero(input coord_set_type c, input logic [VALUE_W-1:0] v,
                               input logic fin);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_coord_level0  <= c[0];
      req_coord_level1  <= c[1];
      req_coord_level2  <= c[2];
      req_coord_level3  <= c[3];
      req_coord_level4  <= c[4];
      req_coord_level5  <= c[5];
      req_coord_level6  <= c[6];
      req_coord_level7  <= c[7];
      req_nonzero_value <= v;
      req_final_nonzero <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // register writes only once every predicted record is out and the sequencer has settled
   task automatic write_num_modes(input logic [NLEV_W-1:0] modes);
      req_valid <= 1'b0;
      do @(posedge clock); while (records_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= modes;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      modes_now = modes;
   endtask

   // mostly ordered tensors with random content, some noise and broken sequences
   task automatic push_random_nonzero();
      coord_set_type c;
      int            depth;
      int            d;
      int            alt;
      logic          fin;
      if (items_sent >= QUIET_FROM) gaps_on = 1'b0;
      if (modes_now < 2)
         depth = 2;
      else if (modes_now > MAX_LEVELS_DEF)
         depth = MAX_LEVELS_DEF;
      else
         depth = int'(modes_now);
      if ($urandom_range(0, 99) < 12) begin
         // noise: arbitrary coordinates, final marker at random
         for (int i = 0; i < LVL_SLOTS; i++) c[i] = $urandom;
         fin = ($urandom_range(0, 3) == 0);
         if (fin) tensor_left = 0;
      end else begin
         if (tensor_left == 0) begin
            // new tensor: wide or narrow starting coordinates
            tensor_left = $urandom_range(1, 14);
            for (int i = 0; i < LVL_SLOTS; i++)
               walk[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
         end else if ($urandom_range(0, 9) != 0) begin
            // step forward at one level, favouring the deeper ones
            d   = $urandom_range(0, depth - 1);
            alt = $urandom_range(0, depth - 1);
            if (alt > d) d = alt;
            walk[d] = walk[d] + $urandom_range(1, 3);
            for (int i = d + 1; i < LVL_SLOTS; i++) walk[i] = $urandom_range(0, 3);
         end
         // levels past num_modes carry junk the block should ignore
         for (int i = depth; i < LVL_SLOTS; i++) walk[i] = $urandom;
         c = walk;
         tensor_left--;
         fin = (tensor_left == 0);
      end
      push_nonzero(c, {$urandom, $urandom}, fin);
   endtask

   initial begin
      coord_set_type c;
      int            phase;
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      req_valid         <= 1'b0;
      req_coord_level0  <= '0;
      req_coord_level1  <= '0;
      req_coord_level2  <= '0;
      req_coord_level3  <= '0;
      req_coord_level4  <= '0;
      req_coord_level5  <= '0;
      req_coord_level6  <= '0;
      req_coord_level7  <= '0;
      req_nonzero_value <= '0;
      req_final_nonzero <= 1'b0;
      gaps_on     = 1'b1;
      modes_now   = NUM_MODES_RESET;
      items_sent  = 0;
      tensor_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // three levels from reset
      c = '0;
      push_nonzero(c, '0, 1'b0);                   // first of a tensor opens fibers at zero
      push_nonzero(c, '1, 1'b0);                   // same coordinates again: leaf only
      c[2] = 32'd5;
      push_nonzero(c, 64'h1, 1'b0);                // change at the leaf level only
      c[1] = 32'd1;
      c[2] = '0;
      push_nonzero(c, 64'h2, 1'b0);                // new fiber in the middle level
      c = '1;
      push_nonzero(c, 64'h8000_0000_0000_0001, 1'b1);  // all-ones coordinates, closes tensor
      c[0] = 32'd1;
      c[1] = 32'd2;
      c[2] = 32'd3;
      push_nonzero(c, 64'h5555_5555_aaaa_aaaa, 1'b1);  // tensor of a single nonzero

      // fewest levels; coordinates above them are ignored
      write_num_modes(4'd2);
      c = '0;
      c[7:2] = '1;
      push_nonzero(c, 64'haaaa_aaaa_5555_5555, 1'b0);
      c[7:2] = '0;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);
      c[1] = 32'd9;
      push_nonzero(c, {$urandom, $urandom}, 1'b1);

      // all eight levels, up to the widest burst of records
      write_num_modes(4'd8);
      c = '1;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);
      c[7] = '0;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);
      c[6] = 32'd3;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);
      c[0] = '0;
      push_nonzero(c, {$urandom, $urandom}, 1'b1);

      // out-of-range settings, some changed in the middle of a tensor
      write_num_modes(4'd0);
      c = '0;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);
      c[1] = 32'h8000_0000;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);
      write_num_modes(4'd15);
      c[5] = 32'd7;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);
      write_num_modes(4'd1);
      push_nonzero(c, {$urandom, $urandom}, 1'b1);
      write_num_modes(4'd9);
      for (int i = 0; i < LVL_SLOTS; i++) c[i] = $urandom;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);
      push_nonzero(c, {$urandom, $urandom}, 1'b1);  // repeat that closes the tensor
      write_num_modes(4'd5);
      c[3] = 32'h0000_ffff;
      push_nonzero(c, {$urandom, $urandom}, 1'b0);  // left open into the random part

      // random phases, each under its own setting
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: begin
               write_num_modes(4'd8);
            end
            1: begin
               write_num_modes(4'd2);
            end
            default: begin
               write_num_modes(NLEV_W'($urandom_range(0, 15)));
            end
         endcase
         // some phases run with no idling at all
         gaps_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(20, 40))
            if (items_sent < ITEM_TARGET) push_random_nonzero();
         phase++;
      end

      // drain, then give stray records a chance to show
      req_valid <= 1'b0;
      do @(posedge clock); while (records_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog: too long with neither channel moving
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/sctcf_pkg.sv
rtl/core/sctcf_track.sv
rtl/core/sctcf_emit.sv
rtl/core/sorted_coo_to_csf_fibers.sv
test/sorted_coo_to_csf_fibers_checker.sv
test/sorted_coo_to_csf_fibers_tb.sv
